>>> src/vrq_pkg.sv
// vrq_pkg: shared types and codes for the variable-length record ring queue.
// Used by vrq_mem, vrq_ctrl and variable_record_ring_queue.
`default_nettype none
package vrq_pkg;

  localparam int OFS_W   = 17;
  localparam int COUNT_W = 12;

  localparam logic       MODE_ENQ = 1'b0;
  localparam logic       MODE_DEQ = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ_LINK,
    S_DEQ_DATA
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] payload_size;
    logic [2:0]  record_kind;
    logic [31:0] message_id;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        record_offset;
    logic [15:0]        out_payload_size;
    logic [2:0]         out_record_kind;
    logic [31:0]        out_message_id;
    logic [7:0]         out_source_id;
    logic [7:0]         out_dest_id;
    logic [COUNT_W-1:0] records_held;
    logic [31:0]        enqueue_attempts;
    logic [31:0]        enqueue_drops;
  } out_item_t;

  typedef struct packed {
    logic [15:0] payload_size;
    logic [2:0]  record_kind;
    logic [31:0] message_id;
    logic [7:0]  source_id;
    logic [7:0]  dest_id;
  } hdr_t;

  typedef struct packed {
    logic             hdr_we;
    logic [OFS_W-1:0] hdr_wofs;
    hdr_t             hdr_wdata;
    logic             link_we;
    logic [OFS_W-1:0] link_wofs;
    logic [OFS_W-1:0] link_wdata;
    logic             rd_en;
    logic [OFS_W-1:0] rd_ofs;
  } mem_req_t;

endpackage
`default_nettype wire

>>> src/variable_record_ring_queue.sv
// variable_record_ring_queue: top level of the variable-length record ring queue.
// Instantiates vrq_ctrl and vrq_mem. Depends on vrq_pkg.
//
// Usage:
//   A command beat (cmd) is taken at a rising edge where start is high and busy
//   is low. mode selects enqueue (header fields in cmd) or dequeue of the head
//   record. Every command yields exactly one result beat on result, marked by
//   done for one cycle; the receiver cannot stall, so it must take every beat.
// Timing:
//   A command that touches the stores holds busy for one cycle after it is
//   taken: an enqueue writes the header and the previous record's link, then
//   its own link; a dequeue reads header and link through the registered read
//   ports of the stores. done is registered from the S_ENQ_LINK or S_DEQ_DATA
//   state. A rejected enqueue or an empty dequeue has done high in the cycle
//   after it is taken and raises no busy cycle. No new command is taken while
//   busy is high; it is set by the second link write of an enqueue through the
//   one write port of the link store and by the registered read of a dequeue.
// Reset:
//   rst (synchronous) empties the queue and clears both counters; store
//   contents are left as they are and are never read before being written.
`default_nettype none
module variable_record_ring_queue #(
  parameter int QUEUE_BYTES       = 65536,
  parameter int HEADER_BYTES      = 24,
  parameter int MAX_PAYLOAD_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire vrq_pkg::in_item_t   cmd,
  output logic                     done,
  output vrq_pkg::out_item_t       result
);
  import vrq_pkg::*;

  mem_req_t         mem_req;
  hdr_t             hdr_rdata;
  logic [OFS_W-1:0] link_rdata;

  vrq_ctrl #(
    .QUEUE_BYTES       (QUEUE_BYTES),
    .HEADER_BYTES      (HEADER_BYTES),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .mem_req    (mem_req),
    .hdr_rdata  (hdr_rdata),
    .link_rdata (link_rdata)
  );

  vrq_mem #(
    .QUEUE_BYTES (QUEUE_BYTES)
  ) u_mem (
    .clk        (clk),
    .req        (mem_req),
    .hdr_rdata  (hdr_rdata),
    .link_rdata (link_rdata)
  );

endmodule
`default_nettype wire

>>> src/vrq_mem.sv
// vrq_mem: header and link stores, one entry per 8-byte slot of the ring.
// One write and one registered read per store each cycle. Depends on vrq_pkg.
`default_nettype none
module vrq_mem #(
  parameter int QUEUE_BYTES = 65536
) (
  input  wire logic                    clk,
  input  wire vrq_pkg::mem_req_t       req,
  output vrq_pkg::hdr_t                hdr_rdata,
  output logic [vrq_pkg::OFS_W-1:0]    link_rdata
);
  import vrq_pkg::*;

  localparam int Depth = QUEUE_BYTES / 8;
  localparam int SlotW = $clog2(Depth);

  hdr_t             hdr_mem  [Depth];
  logic [OFS_W-1:0] link_mem [Depth];

  always_ff @(posedge clk) begin
    if (req.hdr_we) begin
      hdr_mem[req.hdr_wofs[SlotW+2:3]] <= req.hdr_wdata;
    end
    if (req.rd_en) begin
      hdr_rdata <= hdr_mem[req.rd_ofs[SlotW+2:3]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_wofs[SlotW+2:3]] <= req.link_wdata;
    end
    if (req.rd_en) begin
      link_rdata <= link_mem[req.rd_ofs[SlotW+2:3]];
    end
  end

endmodule
`default_nettype wire

>>> src/vrq_ctrl.sv
// vrq_ctrl: command sequencer, ring offsets, counters and result register.
// Drives vrq_mem through mem_req_t. Depends on vrq_pkg.
`default_nettype none
module vrq_ctrl #(
  parameter int QUEUE_BYTES       = 65536,
  parameter int HEADER_BYTES      = 24,
  parameter int MAX_PAYLOAD_BYTES = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire vrq_pkg::in_item_t       cmd,
  output logic                         done,
  output vrq_pkg::out_item_t           result,
  output vrq_pkg::mem_req_t            mem_req,
  input  wire vrq_pkg::hdr_t           hdr_rdata,
  input  wire logic [vrq_pkg::OFS_W-1:0] link_rdata
);
  import vrq_pkg::*;

  localparam int HdrSpan = ((HEADER_BYTES + 7) / 8) * 8;
  localparam logic [OFS_W-1:0] QBytes   = OFS_W'(QUEUE_BYTES);
  localparam logic [OFS_W-1:0] SpanOfs  = OFS_W'(HdrSpan);
  localparam logic [OFS_W-1:0] MaxAlign = OFS_W'(MAX_PAYLOAD_BYTES);

  state_t             state, state_next;
  logic [OFS_W-1:0]   head, head_next;
  logic [OFS_W-1:0]   tail, tail_next;
  logic [OFS_W-1:0]   free, free_next;
  logic [COUNT_W-1:0] count, count_next;
  logic [31:0]        attempts, attempts_next;
  logic [31:0]        drops, drops_next;
  logic [OFS_W-1:0]   pend_ofs, pend_ofs_next;
  logic [OFS_W-1:0]   pend_val, pend_val_next;
  out_item_t          res, res_next;
  logic               done_next;

  // enqueue placement
  logic             empty;
  logic [OFS_W-1:0] aligned, need, h_e, t_e, f_e, room, target;
  logic             too_large, no_space;

  always_comb begin
    empty     = (count == '0);
    aligned   = ({1'b0, cmd.payload_size} + OFS_W'(7)) & ~OFS_W'(7);
    too_large = (aligned > MaxAlign);
    need      = SpanOfs + aligned;
    h_e       = empty ? '0 : head;
    t_e       = empty ? '0 : tail;
    f_e       = empty ? '0 : free;
    room      = (f_e >= QBytes) ? '0 : QBytes - f_e;
    target    = f_e;
    no_space  = 1'b0;
    if (count == COUNT_MAX) begin
      no_space = 1'b1;
    end else if (!empty && f_e == h_e) begin
      no_space = 1'b1;
    end else if (f_e >= h_e) begin
      if (room < need) begin
        if (h_e < need) begin
          no_space = 1'b1;
        end else begin
          target = '0;
        end
      end
    end else if (h_e - f_e < need) begin
      no_space = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      head     <= '0;
      tail     <= '0;
      free     <= '0;
      count    <= '0;
      attempts <= '0;
      drops    <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      head     <= head_next;
      tail     <= tail_next;
      free     <= free_next;
      count    <= count_next;
      attempts <= attempts_next;
      drops    <= drops_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    res      <= res_next;
    pend_ofs <= pend_ofs_next;
    pend_val <= pend_val_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    free_next     = free;
    count_next    = count;
    attempts_next = attempts;
    drops_next    = drops;
    pend_ofs_next = pend_ofs;
    pend_val_next = pend_val;
    res_next      = res;
    done_next     = 1'b0;
    mem_req       = '0;
    busy          = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        if (start) begin
          res_next = '0;
          if (cmd.mode == MODE_ENQ) begin
            attempts_next = attempts + 32'd1;
            res_next.enqueue_attempts = attempts + 32'd1;
            res_next.enqueue_drops    = drops;
            res_next.records_held     = count;
            if (too_large || no_space) begin
              drops_next             = drops + 32'd1;
              res_next.enqueue_drops = drops + 32'd1;
              res_next.status        = too_large ? ST_TOO_LARGE : ST_NO_SPACE;
              if (!too_large) begin
                head_next = h_e;
                tail_next = t_e;
                free_next = f_e;
              end
              done_next = 1'b1;
            end else begin
              mem_req.hdr_we                 = 1'b1;
              mem_req.hdr_wofs               = target;
              mem_req.hdr_wdata.payload_size = cmd.payload_size;
              mem_req.hdr_wdata.record_kind  = cmd.record_kind;
              mem_req.hdr_wdata.message_id   = cmd.message_id;
              mem_req.hdr_wdata.source_id    = cmd.source_id;
              mem_req.hdr_wdata.dest_id      = cmd.dest_id;
              mem_req.link_we                = !empty;
              mem_req.link_wofs              = t_e;
              mem_req.link_wdata             = target;
              head_next              = h_e;
              tail_next              = target;
              free_next              = target + need;
              count_next             = count + COUNT_W'(1);
              pend_ofs_next          = target;
              pend_val_next          = target + need;
              res_next.status        = ST_OK;
              res_next.record_offset = target[15:0];
              res_next.records_held  = count + COUNT_W'(1);
              state_next             = S_ENQ_LINK;
            end
          end else begin
            res_next.enqueue_attempts = attempts;
            res_next.enqueue_drops    = drops;
            res_next.records_held     = count;
            if (empty) begin
              res_next.status = ST_EMPTY;
              done_next       = 1'b1;
            end else begin
              mem_req.rd_en = 1'b1;
              mem_req.rd_ofs = head;
              state_next    = S_DEQ_DATA;
            end
          end
        end
      end
      S_ENQ_LINK: begin
        mem_req.link_we    = 1'b1;
        mem_req.link_wofs  = pend_ofs;
        mem_req.link_wdata = pend_val;
        done_next          = 1'b1;
        state_next         = S_IDLE;
      end
      S_DEQ_DATA: begin
        res_next.status           = ST_OK;
        res_next.record_offset    = head[15:0];
        res_next.out_payload_size = hdr_rdata.payload_size;
        res_next.out_record_kind  = hdr_rdata.record_kind;
        res_next.out_message_id   = hdr_rdata.message_id;
        res_next.out_source_id    = hdr_rdata.source_id;
        res_next.out_dest_id      = hdr_rdata.dest_id;
        res_next.records_held     = count - COUNT_W'(1);
        head_next                 = link_rdata;
        count_next                = count - COUNT_W'(1);
        done_next                 = 1'b1;
        state_next                = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result = res;

endmodule
`default_nettype wire
